FILE: hw/rtl/dahdsr_pkg.sv
// Shared types and constants for the DAHDSR envelope block.
package dahdsr_pkg;

  localparam logic [31:0] UNITY         = 32'h4000_0000;
  localparam logic [15:0] SUSTAIN_COUNT = 16'hFFFF;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCED  = 3'd6;

  // Input item kinds
  localparam logic [1:0] KIND_SAMPLE   = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_DELAY   = 3'd1,
    ST_ATTACK  = 3'd2,
    ST_HOLD    = 3'd3,
    ST_DECAY   = 3'd4,
    ST_SUSTAIN = 3'd5,
    ST_RELEASE = 3'd6,
    ST_FORCED  = 3'd7
  } stage_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [2:0]         stage;
  } out_item_t;

  // Ramp step request: delta / divisor, truncated toward zero
  typedef struct packed {
    logic               start;
    logic signed [32:0] delta;
    logic [15:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

endpackage

FILE: hw/rtl/dahdsr_div.sv
// Bit-serial signed-by-unsigned divider for ramp step computation.
module dahdsr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dahdsr_pkg::div_req_t req_i,
  output dahdsr_pkg::div_rsp_t rsp_o
);

  localparam int unsigned QuoW = 32;
  localparam int unsigned CntW = $clog2(QuoW);

  logic              run_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [15:0]       rem_q;
  logic [QuoW-1:0]   quo_q;
  logic              neg_q;
  logic [15:0]       div_q;

  logic [32:0]       neg_delta;
  logic [QuoW-1:0]   mag;
  logic [16:0]       trial;
  logic              fits;
  logic [QuoW-1:0]   quo_neg;

  assign neg_delta = 33'd0 - req_i.delta;
  // |delta| is at most 2^31, so 32 bits hold the magnitude
  assign mag   = req_i.delta[32] ? neg_delta[QuoW-1:0] : req_i.delta[QuoW-1:0];
  assign trial = {rem_q, quo_q[QuoW-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign quo_neg = {QuoW{1'b0}} - quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !run_q) begin
        cnt_q <= '0;
        if (req_i.divisor == 16'd0) begin
          done_q <= 1'b1;   // zero length ramp: step 0
        end else begin
          run_q <= 1'b1;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QuoW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.start && !run_q) begin
      rem_q <= '0;
      div_q <= req_i.divisor;
      if (req_i.divisor == 16'd0) begin
        quo_q <= '0;
        neg_q <= 1'b0;
      end else begin
        quo_q <= mag;
        neg_q <= req_i.delta[32];
      end
    end else if (run_q) begin
      // remainder stays below the divisor, so 16 bits hold it
      rem_q <= fits ? 16'(trial - {1'b0, div_q}) : trial[15:0];
      quo_q <= {quo_q[QuoW-2:0], fits};
    end
  end

  assign rsp_o.busy = run_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? $signed(quo_neg) : $signed(quo_q);

endmodule

FILE: hw/rtl/dahdsr_envelope_with_smoothing.sv
// Top level: DAHDSR envelope sequencer with level smoother and sample scaling.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries items of three kinds:
//   audio samples, note on and note off. Each audio sample yields exactly one
//   output item on (out_valid_o / out_stall_i): the sample scaled by the
//   smoothed envelope level and the envelope stage. Note events yield none.
//   The block handles one item at a time; in_stall_o is high while it works.
//   A sample passes the check, level, smooth and emit steps on its way to
//   the output when no stage boundary is crossed. Every ramp step (stage
//   change, note on/off) runs the shared serial divider, and a single stage
//   boundary may chain up to two steps (delay to attack to decay).
//   The output register holds its item while out_stall_i is high; the next
//   item is still accepted and processed, and waits at the output stage
//   until the register frees up.
//   Configuration writes (cfg_we_i) take effect at once; the user makes them
//   only while the block is idle, which the block itself does not enforce.
//   Reset clears the envelope to idle, level zero, registers to defaults.
module dahdsr_envelope_with_smoothing (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  dahdsr_pkg::in_item_t                  in_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output dahdsr_pkg::out_item_t                 out_item_o,
  input  logic                                  cfg_we_i,
  input  logic [dahdsr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dahdsr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,    // ready for an item
    S_CHECK,   // stage boundary check, one transition per cycle
    S_DIV,     // waiting on the step divider
    S_LEVEL,   // ramp the level, advance group counters
    S_SMOOTH,  // one-pole smoother
    S_EMIT     // multiply and load the output register
  } state_e;

  // Configuration
  logic [15:0] cfg_delay_q, cfg_attack_q, cfg_hold_q, cfg_decay_q;
  logic [15:0] cfg_release_q, cfg_forced_q;
  logic [30:0] cfg_sustain_q;

  // Sequencer and envelope state
  state_e                 state_q, ret_q;
  dahdsr_pkg::stage_e     stage_q;
  logic [15:0]            groups_q;
  logic [2:0]             phase_q;
  logic signed [31:0]     level_q, step_q, smooth_q;
  logic signed [15:0]     sample_q;
  logic                   zero_q;
  logic                   out_valid_q;
  dahdsr_pkg::out_item_t  out_item_q;
  dahdsr_pkg::div_req_t   div_req_q;
  dahdsr_pkg::div_rsp_t   div_rsp;

  logic                   in_accept;
  logic                   out_free;
  logic signed [32:0]     delta_unity, delta_decay, delta_neg_level;
  logic signed [32:0]     smooth_diff, smooth_inc;
  logic signed [31:0]     prod;

  dahdsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign delta_unity     = $signed({1'b0, dahdsr_pkg::UNITY});
  assign delta_decay     = $signed({2'b00, cfg_sustain_q}) - delta_unity;
  assign delta_neg_level = 33'sd0 - $signed({level_q[31], level_q});

  assign smooth_diff = $signed({level_q[31], level_q}) - $signed({smooth_q[31], smooth_q});
  assign smooth_inc  = smooth_diff >>> 6;
  assign prod        = $signed(smooth_q[31:16]) * sample_q;

  function automatic dahdsr_pkg::div_req_t div_launch(logic signed [32:0] delta,
                                                      logic [15:0] divisor);
    dahdsr_pkg::div_req_t r;
    r.start   = 1'b1;
    r.delta   = delta;
    r.divisor = divisor;
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_delay_q   <= 16'd0;
      cfg_attack_q  <= 16'd1;
      cfg_hold_q    <= 16'd0;
      cfg_decay_q   <= 16'd1;
      cfg_sustain_q <= dahdsr_pkg::UNITY[30:0];
      cfg_release_q <= 16'd1;
      cfg_forced_q  <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dahdsr_pkg::CFG_DELAY:   cfg_delay_q   <= cfg_wdata_i[15:0];
        dahdsr_pkg::CFG_ATTACK:  cfg_attack_q  <= cfg_wdata_i[15:0];
        dahdsr_pkg::CFG_HOLD:    cfg_hold_q    <= cfg_wdata_i[15:0];
        dahdsr_pkg::CFG_DECAY:   cfg_decay_q   <= cfg_wdata_i[15:0];
        dahdsr_pkg::CFG_SUSTAIN: cfg_sustain_q <= cfg_wdata_i;
        dahdsr_pkg::CFG_RELEASE: cfg_release_q <= cfg_wdata_i[15:0];
        dahdsr_pkg::CFG_FORCED:  cfg_forced_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer: state, envelope registers and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      stage_q     <= dahdsr_pkg::ST_IDLE;
      groups_q    <= '0;
      phase_q     <= '0;
      level_q     <= '0;
      step_q      <= '0;
      smooth_q    <= '0;
      sample_q    <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      div_req_q   <= '0;
    end else begin
      // start is a one-cycle pulse; it is only high while waiting in S_DIV
      if (div_req_q.start) begin
        div_req_q.start <= 1'b0;
      end
      // emit reloads the register itself when it frees up
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            case (in_item_i.kind)
              dahdsr_pkg::KIND_NOTE_ON: begin
                if (stage_q == dahdsr_pkg::ST_IDLE || stage_q == dahdsr_pkg::ST_DELAY ||
                    cfg_forced_q == 16'd0) begin
                  level_q <= '0;
                  phase_q <= '0;
                  if (cfg_delay_q != 16'd0) begin
                    stage_q  <= dahdsr_pkg::ST_DELAY;
                    groups_q <= cfg_delay_q;
                    step_q   <= '0;
                  end else begin
                    stage_q   <= dahdsr_pkg::ST_ATTACK;
                    groups_q  <= cfg_attack_q;
                    div_req_q <= div_launch(delta_unity, cfg_attack_q);
                    ret_q     <= S_IDLE;
                    state_q   <= S_DIV;
                  end
                end else if (stage_q != dahdsr_pkg::ST_FORCED) begin
                  // retrigger: quick fade from the current level
                  stage_q   <= dahdsr_pkg::ST_FORCED;
                  groups_q  <= cfg_forced_q;
                  phase_q   <= '0;
                  div_req_q <= div_launch(delta_neg_level, cfg_forced_q);
                  ret_q     <= S_IDLE;
                  state_q   <= S_DIV;
                end
              end
              dahdsr_pkg::KIND_NOTE_OFF: begin
                if (stage_q != dahdsr_pkg::ST_IDLE && stage_q != dahdsr_pkg::ST_FORCED) begin
                  stage_q   <= dahdsr_pkg::ST_RELEASE;
                  groups_q  <= cfg_release_q;
                  phase_q   <= '0;
                  div_req_q <= div_launch(delta_neg_level, cfg_release_q);
                  ret_q     <= S_IDLE;
                  state_q   <= S_DIV;
                end
              end
              dahdsr_pkg::KIND_SAMPLE: begin
                sample_q <= in_item_i.sample_in;
                if (stage_q == dahdsr_pkg::ST_IDLE) begin
                  zero_q  <= 1'b1;
                  state_q <= S_EMIT;
                end else begin
                  zero_q  <= 1'b0;
                  state_q <= S_CHECK;
                end
              end
              default: ;
            endcase
          end
        end

        S_DIV: begin
          if (div_rsp.done) begin
            step_q  <= div_rsp.quot;
            state_q <= ret_q;
          end
        end

        S_CHECK: begin
          if (phase_q != 3'd0 || groups_q != 16'd0) begin
            state_q <= S_LEVEL;
          end else begin
            case (stage_q)
              dahdsr_pkg::ST_ATTACK: begin
                if (cfg_hold_q != 16'd0) begin
                  stage_q  <= dahdsr_pkg::ST_HOLD;
                  groups_q <= cfg_hold_q;
                  level_q  <= $signed(dahdsr_pkg::UNITY);
                  step_q   <= '0;
                end else begin
                  stage_q   <= dahdsr_pkg::ST_DECAY;
                  groups_q  <= cfg_decay_q;
                  div_req_q <= div_launch(delta_decay, cfg_decay_q);
                  ret_q     <= S_CHECK;
                  state_q   <= S_DIV;
                end
              end
              dahdsr_pkg::ST_HOLD: begin
                stage_q   <= dahdsr_pkg::ST_DECAY;
                groups_q  <= cfg_decay_q;
                div_req_q <= div_launch(delta_decay, cfg_decay_q);
                ret_q     <= S_CHECK;
                state_q   <= S_DIV;
              end
              dahdsr_pkg::ST_DECAY: begin
                stage_q  <= dahdsr_pkg::ST_SUSTAIN;
                groups_q <= dahdsr_pkg::SUSTAIN_COUNT;
                level_q  <= $signed({1'b0, cfg_sustain_q});
                step_q   <= '0;
                state_q  <= S_LEVEL;
              end
              dahdsr_pkg::ST_SUSTAIN: begin
                groups_q <= dahdsr_pkg::SUSTAIN_COUNT;
                state_q  <= S_LEVEL;
              end
              dahdsr_pkg::ST_FORCED: begin
                // fade done: restart envelope, then ramp this sample
                level_q <= '0;
                if (cfg_delay_q != 16'd0) begin
                  stage_q  <= dahdsr_pkg::ST_DELAY;
                  groups_q <= cfg_delay_q;
                  step_q   <= '0;
                  state_q  <= S_LEVEL;
                end else begin
                  stage_q   <= dahdsr_pkg::ST_ATTACK;
                  groups_q  <= cfg_attack_q;
                  div_req_q <= div_launch(delta_unity, cfg_attack_q);
                  ret_q     <= S_LEVEL;
                  state_q   <= S_DIV;
                end
              end
              dahdsr_pkg::ST_DELAY: begin
                stage_q   <= dahdsr_pkg::ST_ATTACK;
                groups_q  <= cfg_attack_q;
                div_req_q <= div_launch(delta_unity, cfg_attack_q);
                ret_q     <= S_CHECK;
                state_q   <= S_DIV;
              end
              default: begin
                // release finished
                stage_q <= dahdsr_pkg::ST_IDLE;
                zero_q  <= 1'b1;
                state_q <= S_EMIT;
              end
            endcase
          end
        end

        S_LEVEL: begin
          level_q <= level_q + (step_q >>> 3);
          phase_q <= phase_q + 3'd1;
          if (phase_q == 3'd7) begin
            groups_q <= groups_q - 16'd1;
          end
          state_q <= S_SMOOTH;
        end

        S_SMOOTH: begin
          smooth_q <= smooth_q + smooth_inc[31:0];
          state_q  <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_q           <= 1'b1;
            out_item_q.sample_out <= zero_q ? 16'sd0 : prod[29:14];
            out_item_q.stage      <= stage_q;
            state_q               <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Divider results only arrive while the sequencer waits for them
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider result outside wait state");

  // No division is in flight while the block takes items
  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !div_rsp.busy)
    else $error("divider busy while idle");

  // Idle stage always reports a silent sample
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.stage == 3'(dahdsr_pkg::ST_IDLE) |-> out_item_o.sample_out == 16'sd0)
    else $error("nonzero sample in idle stage");

  // A new output item is only loaded from the emit step
  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_EMIT)
    else $error("output loaded outside emit step");

endmodule

FILE: tb/sv/envelope_check.sv
`timescale 1ns / 1ps
// Envelope predictor and result comparison for the DAHDSR envelope testbench.
module envelope_check
  import dahdsr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           fails_o,
  output int unsigned           outstanding_o,
  output int unsigned           checked_o
);

  // register mirror
  logic [15:0] delay_g, attack_g, hold_g, decay_g, release_g, forced_g;
  logic [30:0] sustain_lvl;

  // envelope state mirror
  stage_e             env_stage;
  logic [15:0]        groups_left;
  logic [2:0]         group_pos;
  logic signed [31:0] env_level, env_step, smooth_level;

  out_item_t   expected_samples[$];
  int unsigned mismatches = 0;
  int unsigned compared = 0;

  // delta / groups, truncated toward zero, wrapped to 32 bits; zero length gives 0
  function automatic logic signed [31:0] step_for(longint delta, logic [15:0] groups);
    longint q;
    if (groups == 16'd0) return 32'sd0;
    q = delta / longint'(groups);
    return q[31:0];
  endfunction

  function automatic void launch_envelope();
    env_level   = 32'sd0;
    groups_left = delay_g;
    if (delay_g != 16'd0) begin
      env_stage = ST_DELAY;
      env_step  = 32'sd0;
    end else begin
      env_stage   = ST_ATTACK;
      groups_left = attack_g;
      env_step    = step_for(longint'(UNITY), attack_g);
    end
  endfunction

  function automatic void enter_decay_ramp();
    env_stage   = ST_DECAY;
    groups_left = decay_g;
    env_step    = step_for(longint'(sustain_lvl) - longint'(UNITY), decay_g);
  endfunction

  // Applies one item to the mirror; returns 1 with the scaled sample for audio items.
  function automatic bit envelope_advance(in_item_t it, output out_item_t res);
    bit     settled;
    longint diff;
    longint sum;
    longint prod;
    res = '0;
    case (it.kind)
      KIND_NOTE_ON: begin
        if (env_stage == ST_IDLE || env_stage == ST_DELAY || forced_g == 16'd0) begin
          launch_envelope();
          group_pos = 3'd0;
        end else if (env_stage != ST_FORCED) begin
          env_stage   = ST_FORCED;
          groups_left = forced_g;
          env_step    = step_for(-longint'(env_level), forced_g);
          group_pos   = 3'd0;
        end
        return 1'b0;
      end
      KIND_NOTE_OFF: begin
        if (env_stage != ST_IDLE && env_stage != ST_FORCED) begin
          env_stage   = ST_RELEASE;
          groups_left = release_g;
          env_step    = step_for(-longint'(env_level), release_g);
          group_pos   = 3'd0;
        end
        return 1'b0;
      end
      KIND_SAMPLE: ;
      default: return 1'b0;
    endcase

    if (env_stage == ST_IDLE) begin
      res.stage = ST_IDLE;
      return 1'b1;
    end

    // stage boundaries chain until a stage with groups left is reached, sustain or a restart settles, or release ends
    if (group_pos == 3'd0) begin
      settled = 1'b0;
      while (groups_left == 16'd0 && !settled) begin
        case (env_stage)
          ST_ATTACK: begin
            groups_left = hold_g;
            if (hold_g != 16'd0) begin
              env_stage = ST_HOLD;
              env_level = UNITY;
              env_step  = 32'sd0;
            end else begin
              enter_decay_ramp();
            end
          end
          ST_HOLD: enter_decay_ramp();
          ST_DECAY: begin
            env_stage   = ST_SUSTAIN;
            groups_left = SUSTAIN_COUNT;
            env_level   = {1'b0, sustain_lvl};
            env_step    = 32'sd0;
            settled     = 1'b1;
          end
          ST_SUSTAIN: begin
            groups_left = SUSTAIN_COUNT;
            settled     = 1'b1;
          end
          ST_FORCED: begin
            launch_envelope();
            settled = 1'b1;
          end
          ST_DELAY: begin
            env_stage   = ST_ATTACK;
            groups_left = attack_g;
            env_step    = step_for(longint'(UNITY), attack_g);
          end
          default: begin
            env_stage = ST_IDLE;
            res.stage = ST_IDLE;
            return 1'b1;
          end
        endcase
      end
    end

    env_level    = env_level + (env_step >>> 3);
    diff         = longint'(env_level) - longint'(smooth_level);
    sum          = longint'(smooth_level) + (diff >>> 6);
    smooth_level = sum[31:0];
    prod = (longint'(smooth_level >>> 16) * longint'($signed(it.sample_in))) >>> 14;

    group_pos = group_pos + 3'd1;
    if (group_pos == 3'd0) groups_left = groups_left - 16'd1;

    res.sample_out = prod[15:0];
    res.stage      = env_stage;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t predicted;
    out_item_t oldest;
    if (!rst_ni) begin
      delay_g      = 16'd0;
      attack_g     = 16'd1;
      hold_g       = 16'd0;
      decay_g      = 16'd1;
      sustain_lvl  = UNITY[30:0];
      release_g    = 16'd1;
      forced_g     = 16'd0;
      env_stage    = ST_IDLE;
      groups_left  = 16'd0;
      group_pos    = 3'd0;
      env_level    = 32'sd0;
      env_step     = 32'sd0;
      smooth_level = 32'sd0;
      expected_samples.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DELAY:   delay_g     = cfg_wdata_i[15:0];
          CFG_ATTACK:  attack_g    = cfg_wdata_i[15:0];
          CFG_HOLD:    hold_g      = cfg_wdata_i[15:0];
          CFG_DECAY:   decay_g     = cfg_wdata_i[15:0];
          CFG_SUSTAIN: sustain_lvl = cfg_wdata_i[30:0];
          CFG_RELEASE: release_g   = cfg_wdata_i[15:0];
          CFG_FORCED:  forced_g    = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      // results first: a result can never belong to the item taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result: sample_out %0d stage %0d",
                 $signed(out_item_i.sample_out), out_item_i.stage);
          mismatches++;
        end else begin
          oldest = expected_samples.pop_front();
          compared++;
          if (out_item_i.sample_out !== oldest.sample_out) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(oldest.sample_out), $signed(out_item_i.sample_out));
            mismatches++;
          end
          if (out_item_i.stage !== oldest.stage) begin
            $error("stage: expected %0d, got %0d", oldest.stage, out_item_i.stage);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (envelope_advance(in_item_i, predicted)) expected_samples.push_back(predicted);
      end
    end
    fails_o       <= mismatches;
    outstanding_o <= expected_samples.size();
    checked_o     <= compared;
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the DAHDSR envelope testbench: clock, reset, stimulus and verdict.
module testbench;
  import dahdsr_pkg::*;

  // item kind that the block drops without a result
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned QUIET_LIMIT   = 4000;  // cycles without any handshake
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned HOLD_OFF      = 400;   // long output back-pressure
  localparam int unsigned PHASES        = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned fails, outstanding, checked;

  // idling knobs, percent of cycles
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  logic        hold_off_req = 1'b0;

  int unsigned n_samples = 0, n_notes = 0, n_unused = 0;
  // sample-run lengths that suit the current envelope lengths
  int unsigned body_span = 16, tail_span = 16;

  dahdsr_envelope_with_smoothing DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  envelope_check scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_item_i    (out_item),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .fails_o       (fails),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stall per cycle, plus one long hold-off on request so
  // the output register and the work stage both fill and in_stall rises.
  initial begin
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: any accepted item on either side resets the count.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("testbench failed");
    $finish;
  end

  // mostly random audio, with the full-scale and zero codes mixed in often
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Drive one item and hold it until the block takes it; then maybe idle.
  task automatic offer(logic [1:0] kind, logic signed [15:0] smp);
    in_item_t it;
    it.kind      = kind;
    it.sample_in = smp;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    case (kind)
      KIND_SAMPLE:                n_samples++;
      KIND_NOTE_ON, KIND_NOTE_OFF: n_notes++;
      default:                    n_unused++;
    endcase
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Let the block go quiet: all results back, then room for a note event
  // still in the divider, since those give no result to wait on.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // All seven registers, then sample-run lengths sized to the envelope.
  task automatic apply_setting(logic [15:0] dly, logic [15:0] atk, logic [15:0] hld,
                               logic [15:0] dcy, logic [30:0] sus, logic [15:0] rel,
                               logic [15:0] frc);
    int unsigned body, tail;
    write_reg(CFG_DELAY,   31'(dly));
    write_reg(CFG_ATTACK,  31'(atk));
    write_reg(CFG_HOLD,    31'(hld));
    write_reg(CFG_DECAY,   31'(dcy));
    write_reg(CFG_SUSTAIN, sus);
    write_reg(CFG_RELEASE, 31'(rel));
    write_reg(CFG_FORCED,  31'(frc));
    cfg_we <= 1'b0;
    @(posedge clk);
    body = 8 * (int'(dly) + int'(atk) + int'(hld) + int'(dcy) + 2);
    tail = 8 * (int'(rel) + 1) + 4;
    body_span = (body > 150) ? 150 : body;
    tail_span = (tail > 60) ? 60 : tail;
  endtask

  // Note sequences with random content make up most of the traffic; the
  // rest is loose items of any kind, unused code included.
  task automatic note_traffic(int unsigned budget);
    int unsigned goal;
    goal = n_samples + n_notes + budget;
    while (n_samples + n_notes < goal) begin
      if ($urandom_range(99) < 80) begin
        offer(KIND_NOTE_ON, pick_sample());
        repeat ($urandom_range(1, body_span)) offer(KIND_SAMPLE, pick_sample());
        // retrigger while sounding: restart or forced fade
        if ($urandom_range(99) < 30) begin
          offer(KIND_NOTE_ON, pick_sample());
          repeat ($urandom_range(1, body_span)) offer(KIND_SAMPLE, pick_sample());
        end
        if ($urandom_range(99) < 85) offer(KIND_NOTE_OFF, pick_sample());
        repeat ($urandom_range(1, tail_span)) offer(KIND_SAMPLE, pick_sample());
      end else begin
        repeat ($urandom_range(1, 6)) offer(2'($urandom_range(3)), pick_sample());
      end
    end
  endtask

  initial begin
    int unsigned mode;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle behavior, ignored events, attack at full-scale input,
    // forced fade with ignored note events inside it, restart, release.
    apply_setting(16'd0, 16'd1, 16'd1, 16'd1, 31'h2000_0000, 16'd1, 16'd1);
    offer(KIND_SAMPLE, 16'sh7FFF);        // idle gives zero
    offer(KIND_SAMPLE, 16'sh8000);
    offer(KIND_UNUSED, 16'sh5A5A);        // dropped
    offer(KIND_NOTE_OFF, 16'sh0000);      // no effect while idle
    offer(KIND_NOTE_ON, 16'shA5A5);       // straight into attack
    offer(KIND_SAMPLE, 16'sh7FFF);
    offer(KIND_SAMPLE, 16'sh8000);
    offer(KIND_SAMPLE, 16'sh0001);
    offer(KIND_SAMPLE, 16'shFFFF);
    offer(KIND_SAMPLE, 16'sh0000);
    offer(KIND_NOTE_ON, 16'sh0000);       // retrigger -> forced fade
    offer(KIND_NOTE_ON, 16'sh0000);       // ignored during the fade
    offer(KIND_NOTE_OFF, 16'sh0000);      // ignored during the fade
    repeat (9) offer(KIND_SAMPLE, pick_sample());  // fade ends, restart
    offer(KIND_NOTE_OFF, 16'sh7FFF);      // release
    offer(KIND_SAMPLE, 16'sh7FFF);
    offer(KIND_SAMPLE, 16'sh8000);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      drain();
      mode = ph % 4;
      case (ph)
        0: apply_setting(16'd0, 16'd1, 16'd0, 16'd1, UNITY[30:0], 16'd1, 16'd0);
        1: apply_setting(16'd1, 16'd2, 16'd1, 16'd2, 31'h2000_0000, 16'd2, 16'd1);
        // zero ramp lengths; forced restart into a zero-length attack
        // makes the group counter wrap
        2: apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 31'h0, 16'd0, 16'd1);
        3: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF,
                         16'hFFFF, 16'hFFFF);
        // sustain above unity: decay ramps upward
        4: apply_setting(16'd0, 16'd3, 16'd2, 16'd3, 31'h7FFF_FFFF, 16'd4, 16'd2);
        5: apply_setting(16'd2, 16'd1, 16'd0, 16'd4, 31'h0800_0000, 16'd3, 16'd3);
        default: apply_setting(16'($urandom_range(4)), 16'($urandom_range(4)),
                               16'($urandom_range(3)), 16'($urandom_range(4)),
                               31'($urandom), 16'($urandom_range(4)),
                               16'($urandom_range(3)));
      endcase
      case (mode)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 74; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 74; end
        default: begin gap_pct = 11; stall_pct = 11; end
      endcase
      // sender keeps offering at full rate while the receiver holds off
      if (ph == 0) hold_off_req <= 1'b1;
      // the last note sequence of a phase runs past its budget
      note_traffic((ph == 3) ? 70 : 140);
    end
    drain();

    $display("Run covered %0d audio samples, %0d note events and %0d unused-kind items",
             n_samples, n_notes, n_unused);
    $display("across %0d register settings; %0d scaled samples compared.",
             PHASES + 1, checked);
    if (fails == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: dahdsr_envelope_with_smoothing.f
hw/rtl/dahdsr_pkg.sv
hw/rtl/dahdsr_div.sv
hw/rtl/dahdsr_envelope_with_smoothing.sv
tb/sv/envelope_check.sv
tb/sv/testbench.sv
